/* rtl/sadq_pkg.sv */
// sadq_pkg: shared constants, codes and control structs for the alarm deadline queue
// used by sadq_alu, sadq_list and sorted_alarm_deadline_queue_core; no dependencies

package sadq_pkg;

    // slot count and derived widths
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // fixed field widths
    localparam int TIME_W  = 32;
    localparam int ID_W    = 4;
    localparam int KIND_W  = 2;
    localparam int TICK_W  = 11;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((ID_W + 2 * TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ID_W + TIME_W + 7) / 8) * 8;

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

    // operation codes carried in the input tuser
    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROCESS  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

    // shared arithmetic unit operations
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;

    typedef struct packed {
        logic              en;
        logic [1:0]        op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    // commands to the ordered slot list; pos doubles as the read position
    typedef struct packed {
        logic              unlink;
        logic              insert;
        logic              pop;
        logic [SLOT_W-1:0] id;
        logic [CNT_W-1:0]  pos;
    } t_list_cmd;

endpackage

/* rtl/sorted_alarm_deadline_queue_core.sv */
// sorted_alarm_deadline_queue_core: top level, sequencer and deadline memory
// depends on sadq_pkg, sadq_alu and sadq_list
//
//   channel   direction  signals                         contents
//   s_axis    in         tvalid tready tdata[71:0] tuser alarm_id, delay_ms, now; tuser kind
//   m_axis    out        tvalid tready tdata[39:0] tuser fired_id, remaining; tuser fired_valid
//   cfg       in         valid ready data[10:0]          ticks_per_ms
//
// one item at a time: s_axis tready is high only in idle, so a new item is taken only
// once the last one is through. schedule compares the new deadline against pending
// slots along the list until the insert point or the tail; process checks the head
// slot by slot and emits one result per fired slot. a result waits in an output
// register; a stalled m_axis holds the sequencer only when the next result is due.
// synchronous active-low reset, no clearing pass.

module sorted_alarm_deadline_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sadq_pkg::TICK_W-1:0]       i_cfg_data,      // ticks_per_ms
    // input items
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sadq_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // alarm_id[3:0], delay_ms[35:4], now[67:36]
    input  logic [sadq_pkg::KIND_W-1:0]       i_s_axis_tuser,  // kind[1:0]
    // result items
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [sadq_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // fired_id[3:0], remaining[35:4]
    output logic                              o_m_axis_tuser,  // fired_valid
    output logic                              o_m_axis_tlast
);
    import sadq_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL      = 4'd1;
    localparam logic [3:0] S_ADD      = 4'd2;
    localparam logic [3:0] S_WR       = 4'd3;
    localparam logic [3:0] S_INS_RD   = 4'd4;
    localparam logic [3:0] S_INS_SUB  = 4'd5;
    localparam logic [3:0] S_INS_CMP  = 4'd6;
    localparam logic [3:0] S_INS_DO   = 4'd7;
    localparam logic [3:0] S_REMOVE   = 4'd8;
    localparam logic [3:0] S_PR_CHK   = 4'd9;
    localparam logic [3:0] S_PR_SUB   = 4'd10;
    localparam logic [3:0] S_PR_CMP   = 4'd11;
    localparam logic [3:0] S_PR_FLUSH = 4'd12;
    localparam logic [3:0] S_PR_LAST  = 4'd13;
    localparam logic [3:0] S_Q_RD     = 4'd14;
    localparam logic [3:0] S_Q_SUB    = 4'd15;

    logic [3:0]        r_state, n_state;
    logic [TICK_W-1:0] r_ticks;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_delay;
    logic [TIME_W-1:0] r_now;
    logic              r_in_range;
    logic [TIME_W-1:0] r_dl_new;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_hold_v, n_hold_v;
    logic [SLOT_W-1:0] r_hold_id, n_hold_id;
    logic              r_q_done, n_q_done;

    // deadline memory with written flags standing in for the zero reset
    logic [TIME_W-1:0] r_dl_mem [SLOTS];
    logic [SLOTS-1:0]  r_dl_written;
    logic [TIME_W-1:0] r_rd_data;
    logic              r_rd_written;
    logic [TIME_W-1:0] rd_val;
    logic              mem_rd;
    logic [SLOT_W-1:0] mem_addr;
    logic              mem_wr;

    // output register
    logic              r_out_v;
    logic [ID_W-1:0]   r_out_id;
    logic [TIME_W-1:0] r_out_rem;
    logic              r_out_fired;
    logic              r_out_last;
    logic              out_free;
    logic              out_load;
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_rem;
    logic              out_fired;
    logic              out_last;

    t_alu_req          alu_req;
    logic [TIME_W-1:0] alu_res;
    t_list_cmd         list_cmd;
    logic [CNT_W-1:0]  list_count;
    logic [SLOT_W-1:0] list_entry;
    logic [SLOT_W-1:0] slot_idx;
    logic              in_acc;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign slot_idx        = SLOT_W'(r_id);
    assign out_free        = !r_out_v || i_m_axis_tready;
    assign rd_val          = r_rd_written ? r_rd_data : '0;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICK_RESET;
        end else if (i_cfg_valid) begin
            r_ticks <= i_cfg_data;
        end
    end

    // input item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id       <= i_s_axis_tdata[ID_W-1:0];
            r_delay    <= i_s_axis_tdata[ID_W+TIME_W-1:ID_W];
            r_now      <= i_s_axis_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];
            r_in_range <= (32'(i_s_axis_tdata[ID_W-1:0]) < 32'(SLOTS));
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_hold_v  = r_hold_v;
        n_hold_id = r_hold_id;
        n_q_done  = r_q_done;
        alu_req   = '{en: 1'b0, op: ALU_ADD, a: '0, b: '0};
        list_cmd  = '{unlink: 1'b0, insert: 1'b0, pop: 1'b0, id: slot_idx, pos: r_pos};
        mem_rd    = 1'b0;
        mem_addr  = slot_idx;
        mem_wr    = 1'b0;
        out_load  = 1'b0;
        out_id    = '0;
        out_rem   = '0;
        out_fired = 1'b0;
        out_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pos    = '0;
                    n_hold_v = 1'b0;
                    n_q_done = 1'b0;
                    case (i_s_axis_tuser)
                        KIND_SCHEDULE: n_state = S_MUL;
                        KIND_REMOVE:   n_state = S_REMOVE;
                        KIND_PROCESS:  n_state = S_PR_CHK;
                        default:       n_state = S_Q_RD;
                    endcase
                end
            end
            // schedule: delay times ticks, plus now
            S_MUL: begin
                if (!r_in_range) begin
                    n_state = S_IDLE;
                end else begin
                    alu_req = '{en: 1'b1, op: ALU_MUL, a: r_delay, b: TIME_W'(r_ticks)};
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                alu_req = '{en: 1'b1, op: ALU_ADD, a: alu_res, b: r_now};
                n_state = S_WR;
            end
            // store the deadline and take the slot out of the list
            S_WR: begin
                mem_wr          = 1'b1;
                list_cmd.unlink = 1'b1;
                n_state         = S_INS_RD;
            end
            // walk the list past slots whose deadline the new one lies after
            S_INS_RD: begin
                if (r_pos >= list_count) begin
                    n_state = S_INS_DO;
                end else begin
                    mem_rd   = 1'b1;
                    mem_addr = list_entry;
                    n_state  = S_INS_SUB;
                end
            end
            S_INS_SUB: begin
                alu_req = '{en: 1'b1, op: ALU_SUB, a: rd_val, b: r_dl_new};
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (alu_res[TIME_W-1]) begin
                    n_pos   = r_pos + CNT_W'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_DO;
                end
            end
            S_INS_DO: begin
                list_cmd.insert = 1'b1;
                n_state         = S_IDLE;
            end
            S_REMOVE: begin
                list_cmd.unlink = r_in_range;
                n_state         = S_IDLE;
            end
            // process: check the head against now
            S_PR_CHK: begin
                if (list_count == '0) begin
                    n_state = r_hold_v ? S_PR_LAST : S_IDLE;
                end else begin
                    mem_rd   = 1'b1;
                    mem_addr = list_entry;
                    n_state  = S_PR_SUB;
                end
            end
            S_PR_SUB: begin
                alu_req = '{en: 1'b1, op: ALU_SUB, a: r_now, b: rd_val};
                n_state = S_PR_CMP;
            end
            S_PR_CMP: begin
                if (alu_res[TIME_W-1]) begin
                    n_state = r_hold_v ? S_PR_LAST : S_IDLE;
                end else if (r_hold_v) begin
                    n_state = S_PR_FLUSH;
                end else begin
                    list_cmd.pop = 1'b1;
                    n_hold_v     = 1'b1;
                    n_hold_id    = list_entry;
                    n_state      = S_PR_CHK;
                end
            end
            // another slot fired, so the held one is not the last
            S_PR_FLUSH: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_fired    = 1'b1;
                    out_id       = ID_W'(r_hold_id);
                    list_cmd.pop = 1'b1;
                    n_hold_id    = list_entry;
                    n_state      = S_PR_CHK;
                end
            end
            S_PR_LAST: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_fired = 1'b1;
                    out_id    = ID_W'(r_hold_id);
                    out_last  = 1'b1;
                    n_hold_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            // query: stored deadline minus now
            S_Q_RD: begin
                if (r_q_done) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_rem  = r_in_range ? alu_res : '0;
                        out_last = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    mem_rd  = 1'b1;
                    n_state = S_Q_SUB;
                end
            end
            S_Q_SUB: begin
                alu_req  = '{en: 1'b1, op: ALU_SUB, a: rd_val, b: r_now};
                n_q_done = 1'b1;
                n_state  = S_Q_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hold_v <= 1'b0;
            r_q_done <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            r_q_done <= n_q_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_hold_id <= n_hold_id;
        if (mem_wr) begin
            r_dl_new <= alu_res;
        end
    end

    // deadline memory: one write or one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_dl_mem[slot_idx] <= alu_res;
        end
        if (mem_rd) begin
            r_rd_data <= r_dl_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_written <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (mem_wr) begin
                r_dl_written[slot_idx] <= 1'b1;
            end
            if (mem_rd) begin
                r_rd_written <= r_dl_written[mem_addr];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id    <= out_id;
            r_out_rem   <= out_rem;
            r_out_fired <= out_fired;
            r_out_last  <= out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - ID_W - TIME_W){1'b0}}, r_out_rem, r_out_id};
    assign o_m_axis_tuser  = r_out_fired;
    assign o_m_axis_tlast  = r_out_last;

    sadq_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_res (alu_res)
    );

    sadq_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (list_cmd),
        .o_count (list_count),
        .o_entry (list_entry)
    );

endmodule

/* rtl/sadq_alu.sv */
// sadq_alu: shared 32-bit add / subtract / multiply unit with a registered result
// depends on sadq_pkg for the request struct and operation codes

module sadq_alu (
    input  logic                          i_clk,
    input  sadq_pkg::t_alu_req            i_req,
    output logic [sadq_pkg::TIME_W-1:0]   o_res
);
    import sadq_pkg::*;

    logic [TIME_W+TICK_W-1:0] mul_full;
    logic [TIME_W-1:0]        n_res;
    logic [TIME_W-1:0]        r_res;

    // multiply by the narrow tick factor, keep the low word
    assign mul_full = {{TICK_W{1'b0}}, i_req.a} * {{TIME_W{1'b0}}, i_req.b[TICK_W-1:0]};

    // operation select
    always_comb begin
        case (i_req.op)
            ALU_ADD: n_res = i_req.a + i_req.b;
            ALU_SUB: n_res = i_req.a - i_req.b;
            ALU_MUL: n_res = mul_full[TIME_W-1:0];
            default: n_res = r_res;
        endcase
    end

    // result register, updated only when the unit is used
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/sadq_list.sv */
// sadq_list: pending slots kept in deadline order, with pending flags and count
// depends on sadq_pkg for sizes and the list command struct

module sadq_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sadq_pkg::t_list_cmd           i_cmd,
    output logic [sadq_pkg::CNT_W-1:0]    o_count,
    output logic [sadq_pkg::SLOT_W-1:0]   o_entry
);
    import sadq_pkg::*;

    logic [SLOT_W-1:0] r_order [SLOTS];
    logic [SLOT_W-1:0] n_order [SLOTS];
    logic [SLOTS-1:0]  r_pending;
    logic [SLOTS-1:0]  n_pending;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [SLOTS-1:0]  match;
    logic [SLOTS-1:0]  from_match;
    logic              seen;

    // locate the slot being unlinked and mark every position from it on
    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            match[j] = (r_order[j] == i_cmd.id) && (CNT_W'(j) < r_count);
            seen = seen | match[j];
            from_match[j] = seen;
        end
    end

    // next order, flags and count
    always_comb begin
        n_order   = r_order;
        n_pending = r_pending;
        n_count   = r_count;
        if (i_cmd.unlink && r_pending[i_cmd.id]) begin
            for (int j = 0; j < SLOTS - 1; j++) begin
                if (from_match[j]) begin
                    n_order[j] = r_order[j+1];
                end
            end
            n_count = r_count - CNT_W'(1);
            n_pending[i_cmd.id] = 1'b0;
        end else if (i_cmd.insert && (r_count < CNT_W'(SLOTS))) begin
            for (int j = 1; j < SLOTS; j++) begin
                if ((CNT_W'(j) > i_cmd.pos) && (CNT_W'(j) <= r_count)) begin
                    n_order[j] = r_order[j-1];
                end
            end
            for (int j = 0; j < SLOTS; j++) begin
                if (CNT_W'(j) == i_cmd.pos) begin
                    n_order[j] = i_cmd.id;
                end
            end
            n_count = r_count + CNT_W'(1);
            n_pending[i_cmd.id] = 1'b1;
        end else if (i_cmd.pop && (r_count != '0)) begin
            for (int j = 0; j < SLOTS - 1; j++) begin
                n_order[j] = r_order[j+1];
            end
            n_count = r_count - CNT_W'(1);
            n_pending[r_order[0]] = 1'b0;
        end
    end

    // order entries hold only slots below the count, no reset needed
    always_ff @(posedge i_clk) begin
        r_order <= n_order;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_count   <= '0;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_entry = r_order[i_cmd.pos[SLOT_W-1:0]];

endmodule

/* verif/sorted_alarm_deadline_queue_core_tb.sv */
// testbench for sorted_alarm_deadline_queue_core: stream stimulus, an alarm-queue scoreboard
// with its own deadline-ordered slot list, random idling and an output back-pressure phase
// depends on sadq_pkg and the sorted_alarm_deadline_queue_core rtl
`timescale 1ns / 1ps

module sorted_alarm_deadline_queue_core_tb;
    import sadq_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 80;      // room for the longest schedule to finish
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;

    // one expected or observed result item
    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remaining;
        logic              last;
    } t_alarm_report;

    // alarm list mirror: applies each operation and holds the reports it must cause
    class alarm_queue_scoreboard;
        logic [TICK_W-1:0] ticks;
        logic [TIME_W-1:0] deadline [SLOTS];
        bit                armed [SLOTS];
        logic [SLOT_W-1:0] order [SLOTS];
        int unsigned       armed_count;
        t_alarm_report     pending_reports [$];
        int unsigned       mismatches;
        int unsigned       reports_checked;

        function new();
            ticks = TICK_RESET;
            armed_count = 0;
            mismatches = 0;
            reports_checked = 0;
            for (int i = 0; i < SLOTS; i++) begin
                deadline[i] = '0;
                armed[i] = 1'b0;
                order[i] = '0;
            end
        endfunction

        // a lies after b when the wraparound difference b - a is negative
        function bit later(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
            logic [TIME_W-1:0] diff;
            diff = b - a;
            return diff[TIME_W-1];
        endfunction

        function void unlink(int slot);
            if (!armed[slot]) return;
            for (int i = 0; i < armed_count; i++) begin
                if (order[i] == slot) begin
                    for (int j = i; j + 1 < armed_count; j++) order[j] = order[j+1];
                    armed_count--;
                    break;
                end
            end
            armed[slot] = 1'b0;
        endfunction

        // goes ahead of the first slot whose deadline is not before its own
        function void link(int slot);
            int pos;
            pos = 0;
            while (pos < armed_count && later(deadline[slot], deadline[order[pos]])) pos++;
            if (armed_count >= SLOTS) return;
            for (int j = armed_count; j > pos; j--) order[j] = order[j-1];
            order[pos] = SLOT_W'(slot);
            armed_count++;
            armed[slot] = 1'b1;
        endfunction

        function void apply_operation(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                      logic [TIME_W-1:0] delay, logic [TIME_W-1:0] now);
            logic [63:0]       prod;
            t_alarm_report     rec;
            int                first_idx;
            int                head;
            case (kind)
                KIND_SCHEDULE: begin
                    if (id < SLOTS) begin
                        prod = {32'b0, delay} * {{(64-TICK_W){1'b0}}, ticks};
                        deadline[id] = prod[TIME_W-1:0] + now;
                        unlink(id);
                        link(id);
                    end
                end
                KIND_REMOVE: begin
                    if (id < SLOTS) unlink(id);
                end
                KIND_PROCESS: begin
                    first_idx = pending_reports.size();
                    while (armed_count > 0) begin
                        head = order[0];
                        if (later(deadline[head], now)) break;
                        for (int j = 0; j + 1 < armed_count; j++) order[j] = order[j+1];
                        armed_count--;
                        armed[head] = 1'b0;
                        rec.fired = 1'b1;
                        rec.id = ID_W'(head);
                        rec.remaining = '0;
                        rec.last = 1'b0;
                        pending_reports.push_back(rec);
                    end
                    // mark the closing report of this process item
                    if (pending_reports.size() > first_idx) begin
                        rec = pending_reports[pending_reports.size()-1];
                        rec.last = 1'b1;
                        pending_reports[pending_reports.size()-1] = rec;
                    end
                end
                default: begin
                    rec.fired = 1'b0;
                    rec.id = '0;
                    rec.remaining = (id < SLOTS) ? deadline[id] - now : '0;
                    rec.last = 1'b1;
                    pending_reports.push_back(rec);
                end
            endcase
        endfunction

        function void check_report(t_alarm_report got);
            t_alarm_report want;
            reports_checked++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected report: fired=%0b id=%0d remaining=%h last=%0b",
                             $realtime, got.fired, got.id, got.remaining, got.last);
                return;
            end
            want = pending_reports.pop_front();
            if (got.fired !== want.fired || got.id !== want.id ||
                got.remaining !== want.remaining || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] report %0d differs: expected fired=%0b id=%0d ",
                             $realtime, reports_checked, want.fired, want.id,
                             "remaining=%h last=%0b, got fired=%0b id=%0d ",
                             want.remaining, want.last, got.fired, got.id,
                             "remaining=%h last=%0b", got.remaining, got.last);
            end
        endfunction
    endclass

    // block pins, inputs driven from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [TICK_W-1:0]     i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [KIND_W-1:0]     i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    alarm_queue_scoreboard alarm_sb;
    bit                    idling = 1'b1;
    int unsigned           rx_hold_cycles = 0;
    int unsigned           items_sent = 0;
    logic [TIME_W-1:0]     cur_now = '0;
    logic [TICK_W-1:0]     cur_ticks = TICK_RESET;

    sorted_alarm_deadline_queue_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    initial begin
        #(10_000_000);
        $display("Mismatches found");
        $finish;
    end

    // compare every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            alarm_sb.check_report({o_m_axis_tuser, o_m_axis_tdata[ID_W-1:0],
                                   o_m_axis_tdata[ID_W+TIME_W-1:ID_W], o_m_axis_tlast});
    end

    // result side: random stalls per item, plus one long hold-off on request
    initial begin
        int gap;
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                gap = idling ? $urandom_range(0, 4) : 0;
                if (gap > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // offer one operation item and note it once accepted
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] now);
        int gap;
        gap = idling ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'({now, delay, id});
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        alarm_sb.apply_operation(kind, id, delay, now);
        items_sent++;
    endtask

    // stop offering, wait for every report, then let a silent operation finish
    task automatic wait_idle();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (alarm_sb.pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ticks(input logic [TICK_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        alarm_sb.ticks = value;
        cur_ticks = value;
    endtask

    // arm every slot with close deadlines (many ties), then expire them all at once
    task automatic fill_and_flush();
        int unsigned step;
        step = (cur_ticks == 0) ? 1 : cur_ticks;
        for (int i = 0; i < SLOTS; i++)
            send_item(KIND_SCHEDULE, ID_W'(i), TIME_W'($urandom_range(0, 3)), cur_now);
        cur_now = cur_now + TIME_W'(3 * step);
        send_item(KIND_PROCESS, ID_W'($urandom_range(0, 15)), $urandom, cur_now);
    endtask

    // mostly time-ordered traffic with small delays, some noise and far jumps
    task automatic random_run(input int count);
        int                r;
        int unsigned       step;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] delay;
        for (int n = 0; n < count; n++) begin
            step  = (cur_ticks == 0) ? 1 : cur_ticks;
            r     = $urandom_range(0, 99);
            id    = ID_W'($urandom_range(0, 15));
            delay = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                                 : TIME_W'($urandom_range(0, 40));
            if (r < 5) begin
                kind    = KIND_W'($urandom_range(0, 3));
                cur_now = $urandom;
            end else begin
                cur_now = cur_now + TIME_W'($urandom_range(0, 8) * step);
                if (r < 45)      kind = KIND_SCHEDULE;
                else if (r < 55) kind = KIND_REMOVE;
                else if (r < 78) kind = KIND_PROCESS;
                else             kind = KIND_QUERY;
                // occasional far jump expires nearly everything
                if (kind == KIND_PROCESS && $urandom_range(0, 19) == 0)
                    cur_now = cur_now + 32'h4000_0000;
            end
            send_item(kind, id, delay, cur_now);
        end
    endtask

    // directed cases at reset tick rate
    task automatic run_directed();
        // slots never armed: stored deadline of zero
        send_item(KIND_QUERY,    4'd5,  32'd0,          32'd0);
        send_item(KIND_QUERY,    4'd15, 32'd0,          32'hFFFF_FFFF);
        // nothing armed yet
        send_item(KIND_PROCESS,  4'd0,  32'd0,          32'd0);
        // extreme delay and time, zero delay at the sign boundary
        send_item(KIND_SCHEDULE, 4'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_item(KIND_SCHEDULE, 4'd15, 32'd0,          32'h8000_0000);
        // equal deadlines: later schedule goes first
        send_item(KIND_SCHEDULE, 4'd1,  32'd5,          32'd100);
        send_item(KIND_SCHEDULE, 4'd2,  32'd5,          32'd100);
        // reschedule of an armed slot
        send_item(KIND_SCHEDULE, 4'd1,  32'd3,          32'd100);
        // remove armed and not armed
        send_item(KIND_REMOVE,   4'd2,  32'hFFFF_FFFF,  32'd100);
        send_item(KIND_REMOVE,   4'd7,  32'd0,          32'd100);
        send_item(KIND_QUERY,    4'd1,  32'd0,          32'd100);
        send_item(KIND_QUERY,    4'd2,  32'd0,          32'd100);
        // expire one at a time across the half-range boundary
        send_item(KIND_PROCESS,  4'd0,  32'd0,          32'd104);
        send_item(KIND_PROCESS,  4'd0,  32'd0,          32'h8000_0000);
        send_item(KIND_PROCESS,  4'd0,  32'd0,          32'hFFFF_FFFF);
        // deadline wraps past zero
        send_item(KIND_SCHEDULE, 4'd4,  32'h20,         32'hFFFF_FFF0);
        send_item(KIND_PROCESS,  4'd3,  32'd0,          32'hFFFF_FFFF);
        send_item(KIND_QUERY,    4'd4,  32'd0,          32'hFFFF_FFFF);
        send_item(KIND_PROCESS,  4'd3,  32'd0,          32'h10);
        // fired slot keeps its deadline
        send_item(KIND_QUERY,    4'd4,  32'd0,          32'h0);
        cur_now = 32'h10;
    endtask

    // main sequence
    initial begin
        alarm_sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        write_ticks(TICK_W'(1024));
        fill_and_flush();
        random_run(80);

        // no idling on either side
        write_ticks(TICK_W'(0));
        idling = 1'b0;
        random_run(40);
        wait_idle();
        idling = 1'b1;

        write_ticks(TICK_W'(2047));
        fill_and_flush();
        random_run(50);

        write_ticks(TICK_W'($urandom_range(2, 1023)));
        fill_and_flush();
        random_run(70);

        // output held off while queries keep coming, so the input stalls
        write_ticks(TICK_W'(1));
        rx_hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_item(KIND_QUERY, ID_W'($urandom_range(0, 15)), $urandom, cur_now);
        random_run(70);
        wait_idle();

        $display("summary: %0d operation items, %0d report items checked", items_sent,
                 alarm_sb.reports_checked);
        $display("summary: tick rates 1, 1024, 0, 2047 and one random; full-queue expiries, %s",
                 "wraparound deadlines and a long output hold-off");
        if (alarm_sb.pending_reports.size() != 0) begin
            $display("%0d expected reports never arrived", alarm_sb.pending_reports.size());
            alarm_sb.mismatches += alarm_sb.pending_reports.size();
        end
        if (alarm_sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
